// File: rtl/core/pip_pkg.sv
package pip_pkg;

  // Default coordinate width of the test point and the vertices
  localparam int unsigned COORD_BITS_DEF = 16;

  // Depth of the job queue between front and back (power of two)
  localparam int unsigned JOB_FIFO_DEPTH = 4;

  // Item kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // Per-job control flags handed from the front to the back
  typedef struct packed {
    logic start;   // item loads a new test point, clear box and parity
    logic vertex;  // item is a vertex, fold it into the box
    logic last;    // close the polygon and emit one result
    logic edge_a;  // edge from previous vertex to this vertex is live
    logic edge_b;  // closing edge from this vertex to the first is live
  } pip_ctrl_t;

endpackage

// File: rtl/core/point_in_polygon_test.sv
// Point-in-polygon test, even-odd crossing rule.
// Input channel (in_valid_i / in_ready_o): one beat per item. kind_i = start
// loads the test point from pos_x_i/pos_y_i and opens a new polygon; kind_i =
// vertex adds the next vertex. last_i on a beat closes the polygon with the
// edge back to the first vertex and asks for one result.
// Output channel (out_valid_o / out_ready_i): one beat per closed polygon,
// inside_res_o = inside, in_box_o = test point within the vertex bounding box.
// A point outside the box always reports outside.
// Throughput: one item per cycle while in_ready_o is high. The front registers
// the edge endpoints into a four-entry job queue; the back computes both edge
// cross products in one registered multiply stage and folds parity and box in
// the next. The result beat is registered once the last job has passed both.
// Stall: a held result stops the back once the next last-marked job reaches
// it, and every job behind that one waits in order; the queue keeps the input
// open until it fills, then in_ready_o drops.
// Reset: test point (0,0), empty polygon, queue and pipeline empty.
module point_in_polygon_test #(
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o,
  output logic                         in_box_o
);

  localparam int unsigned JobW = $bits(pip_pkg::pip_ctrl_t) + 8 * COORD_BITS;

  logic            push, push_ready, pop, pop_valid;
  logic [JobW-1:0] job_in, job_out;

  // Front: hold test point, first and previous vertex; emit one job per beat
  pip_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JobW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .last_i      (last_i),
    .job_push_o  (push),
    .job_ready_i (push_ready),
    .job_o       (job_in)
  );

  // Queue: decouple the front from output stalls
  pip_fifo #(
    .WIDTH (JobW),
    .DEPTH (pip_pkg::JOB_FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .data_i       (job_in),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .data_o       (job_out)
  );

  // Back: crossing test, bounding box, parity, result register
  pip_back #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JobW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (pop_valid),
    .job_pop_o    (pop),
    .job_i        (job_out),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o),
    .in_box_o     (in_box_o)
  );

endmodule

// File: rtl/core/pip_fifo.sv
module pip_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = pip_pkg::JOB_FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/pip_front.sv
module pip_front #(
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int unsigned JOB_W      = $bits(pip_pkg::pip_ctrl_t) + 8 * COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic                         last_i,
  output logic                         job_push_o,
  input  logic                         job_ready_i,
  output logic [JOB_W-1:0]             job_o
);

  localparam int unsigned N = COORD_BITS;

  logic signed [N-1:0] test_x_q, test_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [N-1:0] test_x_n, test_y_n, first_x_n, first_y_n;
  logic                seen_q, seen_n;
  logic                is_vertex, accept;
  pip_pkg::pip_ctrl_t  ctrl;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && job_ready_i;
  assign job_push_o = accept;
  assign is_vertex  = (kind_i == pip_pkg::KIND_VERTEX);

  // A start clears the vertex history; any vertex marks it present
  assign seen_n    = is_vertex;
  assign test_x_n  = is_vertex ? test_x_q : pos_x_i;
  assign test_y_n  = is_vertex ? test_y_q : pos_y_i;
  assign first_x_n = (is_vertex && !seen_q) ? pos_x_i : first_x_q;
  assign first_y_n = (is_vertex && !seen_q) ? pos_y_i : first_y_q;

  always_comb begin
    ctrl.start  = !is_vertex;
    ctrl.vertex = is_vertex;
    ctrl.last   = last_i;
    ctrl.edge_a = is_vertex && seen_q;
    ctrl.edge_b = last_i && seen_n;
  end

  // Job layout: ctrl, test point, previous, current, first vertex
  assign job_o = {ctrl, test_x_n, test_y_n, prev_x_q, prev_y_q,
                  pos_x_i, pos_y_i, first_x_n, first_y_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_x_q  <= '0;
      test_y_q  <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      seen_q    <= 1'b0;
    end else if (accept) begin
      test_x_q  <= test_x_n;
      test_y_q  <= test_y_n;
      first_x_q <= first_x_n;
      first_y_q <= first_y_n;
      if (is_vertex) begin
        prev_x_q <= pos_x_i;
        prev_y_q <= pos_y_i;
      end
      seen_q <= last_i ? 1'b0 : seen_n;
    end
  end

endmodule

// File: rtl/core/pip_back.sv
module pip_back #(
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int unsigned JOB_W      = $bits(pip_pkg::pip_ctrl_t) + 8 * COORD_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_pop_o,
  input  logic [JOB_W-1:0] job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             inside_res_o,
  output logic             in_box_o
);

  localparam int unsigned N  = COORD_BITS;
  localparam int unsigned PW = 2 * N + 2;
  localparam int unsigned DW = PW + 1;
  localparam logic signed [N-1:0] CMax = {1'b0, {(N - 1){1'b1}}};
  localparam logic signed [N-1:0] CMin = {1'b1, {(N - 1){1'b0}}};

  pip_pkg::pip_ctrl_t  j_ctrl;
  logic signed [N-1:0] j_tx, j_ty, j_px, j_py, j_cx, j_cy, j_fx, j_fy;

  assign {j_ctrl, j_tx, j_ty, j_px, j_py, j_cx, j_cy, j_fx, j_fy} = job_i;

  // Stage 1: edge differences and cross products
  logic signed [N:0]    da_t, da_dy, da_dx, da_u;
  logic signed [N:0]    db_t, db_dy, db_dx, db_u;
  logic signed [PW-1:0] pa1_d, pa2_d, pb1_d, pb2_d;
  logic                 cond_a_d, cond_b_d, dypos_a_d, dypos_b_d;

  assign da_t  = (N + 1)'(j_tx) - (N + 1)'(j_px);
  assign da_dy = (N + 1)'(j_cy) - (N + 1)'(j_py);
  assign da_dx = (N + 1)'(j_cx) - (N + 1)'(j_px);
  assign da_u  = (N + 1)'(j_ty) - (N + 1)'(j_py);
  assign db_t  = (N + 1)'(j_tx) - (N + 1)'(j_cx);
  assign db_dy = (N + 1)'(j_fy) - (N + 1)'(j_cy);
  assign db_dx = (N + 1)'(j_fx) - (N + 1)'(j_cx);
  assign db_u  = (N + 1)'(j_ty) - (N + 1)'(j_cy);

  assign pa1_d = da_t * da_dy;
  assign pa2_d = da_dx * da_u;
  assign pb1_d = db_t * db_dy;
  assign pb2_d = db_dx * db_u;

  // Edge straddles the ray's y when exactly one end lies above it
  assign cond_a_d  = j_ctrl.edge_a && ((j_py > j_ty) != (j_cy > j_ty));
  assign cond_b_d  = j_ctrl.edge_b && ((j_cy > j_ty) != (j_fy > j_ty));
  assign dypos_a_d = (j_cy > j_py);
  assign dypos_b_d = (j_fy > j_cy);

  logic                 s1_valid_q;
  pip_pkg::pip_ctrl_t   s1_ctrl_q;
  logic signed [N-1:0]  s1_tx_q, s1_ty_q, s1_cx_q, s1_cy_q;
  logic signed [PW-1:0] pa1_q, pa2_q, pb1_q, pb2_q;
  logic                 cond_a_q, cond_b_q, dypos_a_q, dypos_b_q;

  logic retire, load;
  logic out_valid_q, inside_q, in_box_q;

  assign retire    = s1_valid_q && (!s1_ctrl_q.last || !out_valid_q || out_ready_i);
  assign load      = job_valid_i && (!s1_valid_q || retire);
  assign job_pop_o = load;

  // Stage 2: crossing decision, box and parity update
  logic signed [DW-1:0] diff_a, diff_b;
  logic                 cross_a, cross_b;

  assign diff_a  = DW'(pa1_q) - DW'(pa2_q);
  assign diff_b  = DW'(pb1_q) - DW'(pb2_q);
  assign cross_a = cond_a_q && (dypos_a_q ? (diff_a < 0) : (diff_a > 0));
  assign cross_b = cond_b_q && (dypos_b_q ? (diff_b < 0) : (diff_b > 0));

  logic signed [N-1:0] bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;
  logic signed [N-1:0] bmin_x0, bmax_x0, bmin_y0, bmax_y0;
  logic signed [N-1:0] bmin_x1, bmax_x1, bmin_y1, bmax_y1;
  logic                parity_q, par0, par1, box;

  always_comb begin
    bmin_x0 = s1_ctrl_q.start ? CMax : bmin_x_q;
    bmax_x0 = s1_ctrl_q.start ? CMin : bmax_x_q;
    bmin_y0 = s1_ctrl_q.start ? CMax : bmin_y_q;
    bmax_y0 = s1_ctrl_q.start ? CMin : bmax_y_q;
    par0    = s1_ctrl_q.start ? 1'b0 : parity_q;
    bmin_x1 = (s1_ctrl_q.vertex && s1_cx_q < bmin_x0) ? s1_cx_q : bmin_x0;
    bmax_x1 = (s1_ctrl_q.vertex && s1_cx_q > bmax_x0) ? s1_cx_q : bmax_x0;
    bmin_y1 = (s1_ctrl_q.vertex && s1_cy_q < bmin_y0) ? s1_cy_q : bmin_y0;
    bmax_y1 = (s1_ctrl_q.vertex && s1_cy_q > bmax_y0) ? s1_cy_q : bmax_y0;
    par1    = par0 ^ cross_a ^ cross_b;
    box     = (s1_tx_q >= bmin_x1) && (s1_tx_q <= bmax_x1) &&
              (s1_ty_q >= bmin_y1) && (s1_ty_q <= bmax_y1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_ctrl_q   <= '0;
      out_valid_q <= 1'b0;
      bmin_x_q    <= CMax;
      bmax_x_q    <= CMin;
      bmin_y_q    <= CMax;
      bmax_y_q    <= CMin;
      parity_q    <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_q <= 1'b1;
        s1_ctrl_q  <= j_ctrl;
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end
      if (retire && s1_ctrl_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (retire) begin
        if (s1_ctrl_q.last) begin
          bmin_x_q <= CMax;
          bmax_x_q <= CMin;
          bmin_y_q <= CMax;
          bmax_y_q <= CMin;
          parity_q <= 1'b0;
        end else begin
          bmin_x_q <= bmin_x1;
          bmax_x_q <= bmax_x1;
          bmin_y_q <= bmin_y1;
          bmax_y_q <= bmax_y1;
          parity_q <= par1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_tx_q   <= j_tx;
      s1_ty_q   <= j_ty;
      s1_cx_q   <= j_cx;
      s1_cy_q   <= j_cy;
      pa1_q     <= pa1_d;
      pa2_q     <= pa2_d;
      pb1_q     <= pb1_d;
      pb2_q     <= pb2_d;
      cond_a_q  <= cond_a_d;
      cond_b_q  <= cond_b_d;
      dypos_a_q <= dypos_a_d;
      dypos_b_q <= dypos_b_d;
    end
    if (retire && s1_ctrl_q.last) begin
      inside_q <= box && par1;
      in_box_q <= box;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign in_box_o     = in_box_q;

endmodule
